FILE: src/packbits_row_decoder_defines.svh
// Assertion macros shared by the row decoder modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PACKBITS_ROW_DECODER_DEFINES_SVH
`define PACKBITS_ROW_DECODER_DEFINES_SVH

// check a property at every clock edge outside reset
`define PBRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every clock edge, reset included
`define PBRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pbrd_pkg.sv
// Shared constants and word types of the PackBits row decoder.
// No dependencies.
`default_nettype none

package pbrd_pkg;

  localparam int MAX_ROW_BYTES = 131072;
  localparam int CNT_W         = $clog2(MAX_ROW_BYTES + 1);
  localparam int CFG_W         = 18;
  localparam int EFF_W         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KEEP_W        = (CNT_W > 9) ? CNT_W : 9;
  localparam int BUDGET_W      = 32;
  localparam int POS_W         = 17;

  localparam logic       OP_START   = 1'b0;
  localparam logic       OP_DATA    = 1'b1;
  localparam logic [7:0] NOP_HEADER = 8'd128;
  localparam logic [8:0] RUN_BASE   = 9'd257;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [7:0]          data_byte;
    logic [BUDGET_W-1:0] row_budget;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       out_value;
    logic [7:0]       out_repeat;
    logic [POS_W-1:0] out_position;
    logic             row_end;
    logic             status;
  } out_word_t;

endpackage

`default_nettype wire

FILE: src/packbits_row_decoder.sv
// PackBits row decoder: input register, one pass of decode logic, result register.
// Throughput 1 word per cycle unless a stalled result holds the pipe.
// The input register still takes a word while the result waits, but only if it is empty.
// Synchronous active-low reset empties both registers, makes the decoder idle, row length 1.
// Top level; depends on pbrd_pkg, pbrd_engine and packbits_row_decoder_defines.svh.
`default_nettype none
`include "packbits_row_decoder_defines.svh"

module packbits_row_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [pbrd_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire pbrd_pkg::in_word_t           in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pbrd_pkg::out_word_t               out_word
);
  import pbrd_pkg::*;

  logic [CFG_W-1:0] row_length_r;
  logic             in_valid_r, in_valid_nxt;
  in_word_t         in_word_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic             advance;
  logic             accept;
  logic             step_en;
  logic             step_emit;
  out_word_t        step_res;
  logic [CNT_W-1:0] eff_len;

  assign eff_len  = (EFF_W'(row_length_r) > EFF_W'(MAX_ROW_BYTES)) ?
                    CNT_W'(MAX_ROW_BYTES) : CNT_W'(row_length_r);
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign step_en  = in_valid_r && advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  pbrd_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step_en),
    .word  (in_word_r),
    .len   (eff_len),
    .emit  (step_emit),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= CFG_W'(1);
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_length_r <= cfg_data;
      end
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        out_valid_r <= step_en && step_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PBRD_ASSERT(a_held_word_kept, (in_valid_r && !advance) |=> in_valid_r, "held input word dropped")
  `PBRD_ASSERT(a_out_held, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_word_r)), "stalled result moved")
  `PBRD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !in_valid_r), "pipe not empty after reset")

endmodule

`default_nettype wire

FILE: src/pbrd_engine.sv
// Decoder state and single-pass next-state logic for one compressed word.
// Depends on pbrd_pkg and packbits_row_decoder_defines.svh.
`default_nettype none
`include "packbits_row_decoder_defines.svh"

module pbrd_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire pbrd_pkg::in_word_t          word,
  input  wire logic [pbrd_pkg::CNT_W-1:0]  len,
  output logic                             emit,
  output pbrd_pkg::out_word_t              res
);
  import pbrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_LITERAL,
    PH_RUN,
    PH_SKIP
  } phase_t;

  phase_t              phase_r,  phase_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [CNT_W-1:0]    done_r,   done_nxt;
  logic [7:0]          lit_r,    lit_nxt;
  logic [7:0]          run_r,    run_nxt;

  logic [BUDGET_W-1:0] bl_dec;
  logic [7:0]          hdr_lit;
  logic [7:0]          hdr_run;
  logic [CNT_W-1:0]    room;
  logic [KEEP_W-1:0]   keep;
  logic                settle;
  logic                fail;

  always_comb begin
    bl_dec     = budget_r - BUDGET_W'(budget_r != '0);
    hdr_lit    = word.data_byte + 8'd1;
    hdr_run    = 8'(RUN_BASE - {1'b0, word.data_byte});
    room       = len - done_r;
    keep       = '0;
    if (done_r < len) begin
      keep = (KEEP_W'(room) < KEEP_W'(run_r)) ? KEEP_W'(room) : KEEP_W'(run_r);
    end

    phase_nxt  = phase_r;
    budget_nxt = budget_r;
    done_nxt   = done_r;
    lit_nxt    = lit_r;
    run_nxt    = run_r;
    emit       = 1'b0;
    settle     = 1'b0;
    fail       = 1'b0;
    res              = '0;
    res.out_position = POS_W'(done_r);

    if (en) begin
      if (word.opcode == OP_START) begin
        budget_nxt       = word.row_budget;
        done_nxt         = '0;
        lit_nxt          = '0;
        run_nxt          = '0;
        res.out_position = '0;
        if (len == '0) begin
          phase_nxt = PH_SKIP;
          if (word.row_budget == '0) begin
            emit        = 1'b1;
            res.row_end = 1'b1;
            res.status  = STATUS_OK;
            phase_nxt   = PH_IDLE;
          end
        end else if (word.row_budget == '0) begin
          emit        = 1'b1;
          res.row_end = 1'b1;
          res.status  = STATUS_INVALID;
          phase_nxt   = PH_IDLE;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end else if (phase_r != PH_IDLE) begin
        budget_nxt = bl_dec;
        case (phase_r)
          PH_HEADER: begin
            if (word.data_byte == NOP_HEADER) begin
              fail = (bl_dec == '0);
            end else if (word.data_byte < NOP_HEADER) begin
              lit_nxt = hdr_lit;
              if (BUDGET_W'(hdr_lit) > bl_dec) begin
                fail = 1'b1;
              end else begin
                phase_nxt = PH_LITERAL;
              end
            end else begin
              run_nxt = hdr_run;
              if (bl_dec == '0) begin
                fail = 1'b1;
              end else begin
                phase_nxt = PH_RUN;
              end
            end
            if (fail) begin
              emit        = 1'b1;
              res.row_end = 1'b1;
              res.status  = STATUS_INVALID;
              phase_nxt   = PH_IDLE;
            end
          end
          PH_LITERAL: begin
            lit_nxt = lit_r - 8'(lit_r != '0);
            if (done_r < len) begin
              emit           = 1'b1;
              res.out_value  = word.data_byte;
              res.out_repeat = 8'd1;
              done_nxt       = done_r + CNT_W'(1);
            end
            settle = 1'b1;
          end
          PH_RUN: begin
            if (keep != '0) begin
              emit           = 1'b1;
              res.out_value  = word.data_byte;
              res.out_repeat = 8'(keep);
            end
            done_nxt = done_r + CNT_W'(keep);
            settle   = 1'b1;
          end
          PH_SKIP: begin
            settle = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase

        if (settle) begin
          if (done_nxt >= len) begin
            phase_nxt = PH_SKIP;
            if (bl_dec == '0) begin
              emit        = 1'b1;
              res.row_end = 1'b1;
              res.status  = STATUS_OK;
              phase_nxt   = PH_IDLE;
            end
          end else if (phase_r == PH_LITERAL && lit_nxt != '0) begin
            phase_nxt = PH_LITERAL;
          end else begin
            phase_nxt = PH_HEADER;
            if (bl_dec == '0) begin
              emit        = 1'b1;
              res.row_end = 1'b1;
              res.status  = STATUS_INVALID;
              phase_nxt   = PH_IDLE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      budget_r <= '0;
      done_r   <= '0;
      lit_r    <= '0;
      run_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      budget_r <= budget_nxt;
      done_r   <= done_nxt;
      lit_r    <= lit_nxt;
      run_r    <= run_nxt;
    end
  end

  `PBRD_ASSERT(a_repeat_bound, emit |-> (res.out_repeat <= 8'd128), "repeat count above 128")
  `PBRD_ASSERT(a_end_to_idle, (en && emit && res.row_end) |=> (phase_r == PH_IDLE), "row ended but decoder not idle")
  `PBRD_ASSERT(a_idle_data_silent, (en && word.opcode == OP_DATA && phase_r == PH_IDLE) |-> !emit, "data word while idle produced a result")

endmodule

`default_nettype wire

FILE: tb/packbits_row_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for packbits_row_decoder: a scoreboard class decodes every accepted
// input word in step with the block and checks each result word in order.
// Depends on pbrd_pkg and the packbits_row_decoder RTL.

module packbits_row_decoder_tb;
  import pbrd_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 10;
  localparam int RUN_LIMIT_NS  = 3000000;
  localparam int MAX_REPORTS   = 10;
  localparam int BULK_WORDS    = 800;
  localparam int TOTAL_WORDS   = 950;

  typedef enum logic [2:0] {
    DEC_IDLE, DEC_HEADER, DEC_LITERAL, DEC_RUN, DEC_SKIP
  } dec_phase_t;

  typedef enum int {ROW_CLEAN, ROW_PADDED, ROW_SHORT, ROW_CUT} row_shape_t;

  class row_scoreboard;
    logic [CFG_W-1:0] row_len_reg;
    logic [31:0]      budget_left;
    logic [17:0]      bytes_done;
    dec_phase_t       phase;
    logic [7:0]       literal_left;
    logic [7:0]       run_len;
    out_word_t        expected_q[$];
    int               fault_count;

    function new();
      row_len_reg  = CFG_W'(1);
      budget_left  = '0;
      bytes_done   = '0;
      phase        = DEC_IDLE;
      literal_left = '0;
      run_len      = '0;
      fault_count  = 0;
    endfunction

    function void set_row_length(logic [CFG_W-1:0] v);
      row_len_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void settle_row(logic [17:0] len, inout out_word_t r, inout bit emit);
      if (bytes_done >= len) begin
        phase = DEC_SKIP;
        if (budget_left == 0) begin
          r.row_end = 1'b1;
          r.status  = STATUS_OK;
          emit      = 1'b1;
          phase     = DEC_IDLE;
        end
      end else if (!(phase == DEC_LITERAL && literal_left != 0)) begin
        phase = DEC_HEADER;
        if (budget_left == 0) begin
          r.row_end = 1'b1;
          r.status  = STATUS_INVALID;
          emit      = 1'b1;
          phase     = DEC_IDLE;
        end
      end
    endfunction

    function bit decode_word(in_word_t w, output out_word_t r);
      logic [17:0] len;
      logic [17:0] keep;
      bit          emit;
      bit          fail;
      len  = (row_len_reg > CFG_W'(MAX_ROW_BYTES)) ? 18'(MAX_ROW_BYTES) : 18'(row_len_reg);
      emit = 1'b0;
      fail = 1'b0;
      r    = '0;
      r.out_position = bytes_done[POS_W-1:0];
      if (w.opcode == OP_START) begin
        budget_left    = w.row_budget;
        bytes_done     = '0;
        literal_left   = '0;
        run_len        = '0;
        r.out_position = '0;
        if (len == 0) begin
          phase = DEC_SKIP;
          if (w.row_budget == 0) begin
            r.row_end = 1'b1;
            emit      = 1'b1;
            phase     = DEC_IDLE;
          end
        end else if (w.row_budget == 0) begin
          r.row_end = 1'b1;
          r.status  = STATUS_INVALID;
          emit      = 1'b1;
          phase     = DEC_IDLE;
        end else begin
          phase = DEC_HEADER;
        end
      end else if (phase != DEC_IDLE) begin
        if (budget_left != 0) budget_left = budget_left - 32'd1;
        case (phase)
          DEC_HEADER: begin
            if (w.data_byte == NOP_HEADER) begin
              fail = (budget_left == 0);
            end else if (w.data_byte < NOP_HEADER) begin
              literal_left = w.data_byte + 8'd1;
              if (literal_left > budget_left) fail = 1'b1;
              else phase = DEC_LITERAL;
            end else begin
              run_len = 8'(RUN_BASE - {1'b0, w.data_byte});
              if (budget_left == 0) fail = 1'b1;
              else phase = DEC_RUN;
            end
            if (fail) begin
              r.row_end = 1'b1;
              r.status  = STATUS_INVALID;
              emit      = 1'b1;
              phase     = DEC_IDLE;
            end
          end
          DEC_LITERAL: begin
            if (literal_left != 0) literal_left = literal_left - 8'd1;
            if (bytes_done < len) begin
              r.out_value  = w.data_byte;
              r.out_repeat = 8'd1;
              emit         = 1'b1;
              bytes_done   = bytes_done + 18'd1;
            end
            settle_row(len, r, emit);
          end
          DEC_RUN: begin
            keep = '0;
            if (bytes_done < len) begin
              keep = len - bytes_done;
              if (keep > 18'(run_len)) keep = 18'(run_len);
            end
            if (keep != 0) begin
              r.out_value  = w.data_byte;
              r.out_repeat = keep[7:0];
              emit         = 1'b1;
            end
            bytes_done = bytes_done + keep;
            settle_row(len, r, emit);
          end
          default: settle_row(len, r, emit);
        endcase
      end
      return emit;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      if (decode_word(w, r)) expected_q.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected result word at %0t: value %0d repeat %0d pos %0d",
                   $realtime, got.out_value, got.out_repeat, got.out_position,
                   " end %0b status %0b", got.row_end, got.status);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.out_value !== exp_w.out_value || got.out_repeat !== exp_w.out_repeat ||
          got.out_position !== exp_w.out_position || got.row_end !== exp_w.row_end ||
          got.status !== exp_w.status) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("mismatch at %0t: expected value %0d repeat %0d pos %0d end %0b status %0b",
                   $realtime, exp_w.out_value, exp_w.out_repeat, exp_w.out_position,
                   exp_w.row_end, exp_w.status,
                   ", got value %0d repeat %0d pos %0d end %0b status %0b",
                   got.out_value, got.out_repeat, got.out_position, got.row_end,
                   got.status);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_word;

  row_scoreboard sb;
  bit            sender_gaps   = 1'b1;
  bit            receiver_gaps = 1'b1;
  bit            hold_req      = 1'b0;
  int unsigned   useful_words  = 0;
  int unsigned   word_goal     = BULK_WORDS;

  packbits_row_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  function in_word_t start_word(logic [31:0] budget);
    in_word_t w;
    w.opcode     = OP_START;
    w.data_byte  = 8'($urandom_range(0, 255));
    w.row_budget = budget;
    return w;
  endfunction

  function in_word_t data_word(logic [7:0] b);
    in_word_t w;
    w.opcode     = OP_DATA;
    w.data_byte  = b;
    w.row_budget = $urandom();
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_length(logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_row_length(v);
    cfg_we <= 1'b0;
  endtask

  task automatic send_row(int unsigned len, row_shape_t shape);
    logic [7:0]  stream[$];
    logic [7:0]  val;
    int unsigned target, made, n, budget, sent_n, i;
    target = (len > 300) ? $urandom_range(1, 200) : len;
    if (target != 0 && useful_words + target > word_goal)
      target = (word_goal > useful_words) ? word_goal - useful_words : 1;
    made   = 0;
    while (made < target) begin
      case ($urandom_range(0, 9))
        0: stream.push_back(NOP_HEADER);
        1, 2, 3, 4: begin
          n   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
          val = 8'(n - 1);
          stream.push_back(val);
          repeat (n) begin
            val = 8'($urandom_range(0, 255));
            stream.push_back(val);
          end
          made += n;
        end
        default: begin
          n   = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 10);
          val = 8'(257 - n);
          stream.push_back(val);
          val = 8'($urandom_range(0, 255));
          stream.push_back(val);
          made += n;
        end
      endcase
    end
    if (target == 0) begin
      repeat ($urandom_range(0, 3)) begin
        val = 8'($urandom_range(0, 255));
        stream.push_back(val);
      end
    end
    budget = stream.size();
    sent_n = stream.size();
    case (shape)
      ROW_PADDED: begin
        repeat ($urandom_range(1, 4)) begin
          val = 8'($urandom_range(0, 255));
          stream.push_back(val);
        end
        budget = stream.size();
        sent_n = stream.size();
      end
      ROW_SHORT: budget = (stream.size() > 1) ? $urandom_range(1, stream.size() - 1) : 0;
      ROW_CUT: begin
        budget = stream.size() + $urandom();
        sent_n = $urandom_range(0, stream.size());
      end
      default: ;
    endcase
    send_word(start_word(budget));
    useful_words++;
    for (i = 0; i < sent_n; i++) begin
      send_word(data_word(stream[i]));
      if (i < budget) useful_words++;
    end
  endtask

  task automatic run_phase(int unsigned phase_no);
    int unsigned len, eff, rows;
    row_shape_t  shape;
    case (phase_no)
      0: len = 1;
      1: len = 0;
      2: len = 2;
      3: len = 5;
      4: len = 16;
      5: len = 64;
      6: len = 255;
      7: len = 300;
      8: len = MAX_ROW_BYTES;
      9: len = (1 << CFG_W) - 1;
      default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
    endcase
    wait_idle();
    write_row_length(CFG_W'(len));
    eff  = (len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : len;
    rows = (eff > 64) ? $urandom_range(1, 2) : $urandom_range(2, 6);
    repeat (rows) begin
      if ($urandom_range(0, 7) == 0) send_word(data_word(8'($urandom_range(0, 255))));
      if ($urandom_range(0, 9) == 0) begin
        send_word(start_word($urandom()));
        repeat ($urandom_range(0, 4)) send_word(data_word(8'($urandom_range(0, 255))));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: shape = ROW_CLEAN;
        5, 6:          shape = ROW_PADDED;
        7, 8:          shape = ROW_SHORT;
        default:       shape = ROW_CUT;
      endcase
      send_row(eff, shape);
    end
  endtask

  initial begin
    int unsigned phase_no;
    int          drain;
    sb       = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data with no row open is dropped
    send_word(data_word(8'hFF));
    send_word(start_word(32'd2));
    send_word(data_word(8'h00));
    send_word(data_word(8'hAA));
    send_word(start_word(32'd0));
    // clipped run, then a new start drops the row
    send_word(start_word(32'hFFFF_FFFF));
    send_word(data_word(8'h81));
    send_word(data_word(8'h55));
    send_word(start_word(32'd2));
    send_word(data_word(NOP_HEADER));
    send_word(data_word(8'hFF));
    send_word(start_word(32'd3));
    send_word(data_word(8'h02));
    wait_idle();
    write_row_length('0);
    send_word(start_word(32'd0));
    send_word(start_word(32'd2));
    send_word(data_word(8'h12));
    send_word(data_word(8'h34));
    wait_idle();
    write_row_length('1);
    send_word(start_word(32'd2));
    send_word(data_word(8'h81));
    send_word(data_word(8'h37));
    send_word(start_word(32'd1));
    send_word(data_word(NOP_HEADER));
    wait_idle();
    write_row_length(CFG_W'(10));
    send_word(start_word(32'd6));
    send_word(data_word(8'h01));
    send_word(data_word(8'hC3));
    send_word(data_word(8'h3C));
    // shrink the row below what is already decoded
    wait_idle();
    write_row_length(CFG_W'(1));
    send_word(data_word(8'h00));
    send_word(data_word(8'h99));
    send_word(data_word(8'h00));

    // hold the result side while a long literal streams in
    wait_idle();
    write_row_length(CFG_W'(MAX_ROW_BYTES));
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    send_word(start_word(32'd130));
    send_word(data_word(8'h7F));
    repeat (128) send_word(data_word(8'($urandom_range(0, 255))));
    send_word(data_word(NOP_HEADER));
    sender_gaps = 1'b1;

    phase_no = 0;
    while (useful_words < BULK_WORDS) begin
      run_phase(phase_no);
      phase_no++;
    end
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    word_goal     = TOTAL_WORDS;
    do begin
      run_phase(phase_no);
      phase_no++;
    end while (useful_words < TOTAL_WORDS);

    in_valid <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.fault_count += sb.pending();

    if (sb.fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
